FILE: hdl/cpida_pkg.sv
// Shared types and constants of the cyclic process identifier allocator.
package cpida_pkg;

  // Default sizes of the identifier space and of the live table.
  localparam int MAX_IDS_DEF     = 128;
  localparam int TABLE_DEPTH_DEF = 64;

  // Fixed widths of the beat fields.
  localparam int PID_W    = 7;
  localparam int STATUS_W = 2;

  // Request opcodes.
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  // What a token does as it travels along the row of cells.
  typedef enum logic [1:0] {
    TOK_SEARCH  = 2'd0,
    TOK_INSERT  = 2'd1,
    TOK_RELEASE = 2'd2
  } tok_op_e;

  // Control part of a token handed from one cell to the next.
  typedef struct packed {
    logic    vld;
    tok_op_e op;
    logic    hit;
  } tok_ctrl_t;

endpackage

FILE: hdl/cpida_cell.sv
// One table slot of the allocator: holds a live identifier and forwards the token.
module cpida_cell #(
  parameter int MAX_IDS = cpida_pkg::MAX_IDS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cpida_pkg::tok_ctrl_t          tok_i,
  input  logic [$clog2(MAX_IDS)-1:0]    key_i,
  input  logic [$clog2(MAX_IDS):0]      bound_i,
  output cpida_pkg::tok_ctrl_t          tok_o,
  output logic [$clog2(MAX_IDS)-1:0]    key_o,
  output logic [$clog2(MAX_IDS):0]      bound_o
);

  localparam int IdW = $clog2(MAX_IDS);
  localparam int BW  = IdW + 1;
  localparam logic [BW-1:0] MaxIdsB = BW'(MAX_IDS);

  logic                 valid_q, valid_d;
  logic [IdW-1:0]       id_q, id_d;
  cpida_pkg::tok_ctrl_t tok_q, tok_d;
  logic [IdW-1:0]       key_q, key_d;
  logic [BW-1:0]        bound_q, bound_d;
  logic [BW-1:0]        key_inc;

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    tok_d   = tok_i;
    key_d   = key_i;
    bound_d = bound_i;
    key_inc = {1'b0, key_i} + BW'(1);
    if (tok_i.vld) begin
      case (tok_i.op)
        cpida_pkg::TOK_SEARCH: begin
          // A live match pushes the candidate up by one, wrapping to 1.
          if (valid_q) begin
            if (id_q == key_i) begin
              tok_d.hit = 1'b1;
              key_d     = (key_inc >= MaxIdsB) ? IdW'(1) : key_inc[IdW-1:0];
            end else if (id_q > key_i && {1'b0, id_q} < bound_i) begin
              bound_d = {1'b0, id_q};
            end
          end
        end
        cpida_pkg::TOK_INSERT: begin
          // The first empty slot along the row takes the identifier.
          if (!valid_q && !tok_i.hit) begin
            valid_d   = 1'b1;
            id_d      = key_i;
            tok_d.hit = 1'b1;
          end
        end
        cpida_pkg::TOK_RELEASE: begin
          if (valid_q && !tok_i.hit && id_q == key_i) begin
            valid_d   = 1'b0;
            tok_d.hit = 1'b1;
          end
        end
        default: begin
          tok_d.vld = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q    <= id_d;
    key_q   <= key_d;
    bound_q <= bound_d;
  end

  assign tok_o   = tok_q;
  assign key_o   = key_q;
  assign bound_o = bound_q;

endmodule

FILE: hdl/cyclic_process_id_allocator_core.sv
// Top level of the cyclic process identifier allocator with its row of table cells.
//
// Usage: the input channel carries one request per beat (opcode plus the identifier to
// release); the output channel returns one beat per request with new_pid and status.
// Both channels use valid and stall; a beat moves when valid is high and stall is low.
// The live table is a row of TABLE_DEPTH cells. A token enters the first cell and moves
// one cell per cycle; one pass carries it from the first cell to the tail.
// A release and a fast-path allocation take one pass. An allocation that wraps or
// reaches the cached safe bound repeats search passes until one finds no live match,
// then runs one insert pass, two passes in the common case. Full-table and
// out-of-range requests skip the table and go straight to the result. One request is
// in flight at a time; the next one is accepted as soon as the previous result sits
// in the output register, even while it is stalled.
// A finished result that finds the output register still stalled waits in the core.
// Reset empties the table at once through the per-slot valid bits (no clearing pass),
// sets the last given identifier and the safe bound to MAX_IDS, and clears the count.
module cyclic_process_id_allocator_core #(
  parameter int MAX_IDS     = cpida_pkg::MAX_IDS_DEF,
  parameter int TABLE_DEPTH = cpida_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           opcode_i,
  input  logic [cpida_pkg::PID_W-1:0]    released_pid_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [cpida_pkg::PID_W-1:0]    new_pid_o,
  output logic [cpida_pkg::STATUS_W-1:0] status_o
);

  localparam int IdW  = $clog2(MAX_IDS);
  localparam int BW   = IdW + 1;
  localparam int CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [BW-1:0] MaxIdsB = BW'(MAX_IDS);

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_PASS = 2'd1,
    S_DONE = 2'd2
  } state_e;

  state_e state_q;

  // Allocator bookkeeping.
  logic [BW-1:0]   last_given_q;
  logic [BW-1:0]   safe_bound_q;
  logic [CntW-1:0] live_count_q;

  // Token launched into the first cell.
  cpida_pkg::tok_ctrl_t launch_ctrl_q;
  logic [IdW-1:0]       launch_key_q;
  logic [BW-1:0]        launch_bound_q;

  // Result waiting for the output register, and the output register itself.
  logic [cpida_pkg::PID_W-1:0] res_pid_q;
  cpida_pkg::status_e          res_status_q;
  logic                        out_valid_q;
  logic [cpida_pkg::PID_W-1:0] new_pid_q;
  cpida_pkg::status_e          status_q;

  // The row of cells; index 0 is the launch point, index TABLE_DEPTH the tail.
  cpida_pkg::tok_ctrl_t chain_ctrl  [TABLE_DEPTH+1];
  logic [IdW-1:0]       chain_key   [TABLE_DEPTH+1];
  logic [BW-1:0]        chain_bound [TABLE_DEPTH+1];

  cpida_pkg::tok_ctrl_t tail_ctrl;
  logic [IdW-1:0]       tail_key;
  logic [BW-1:0]        tail_bound;

  assign chain_ctrl[0]  = launch_ctrl_q;
  assign chain_key[0]   = launch_key_q;
  assign chain_bound[0] = launch_bound_q;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    cpida_cell #(
      .MAX_IDS(MAX_IDS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (chain_ctrl[g]),
      .key_i  (chain_key[g]),
      .bound_i(chain_bound[g]),
      .tok_o  (chain_ctrl[g+1]),
      .key_o  (chain_key[g+1]),
      .bound_o(chain_bound[g+1])
    );
  end

  assign tail_ctrl  = chain_ctrl[TABLE_DEPTH];
  assign tail_key   = chain_key[TABLE_DEPTH];
  assign tail_bound = chain_bound[TABLE_DEPTH];

  // Request decode. The candidate is the last given identifier plus one; reaching the
  // top of the space wraps it to 1 and forces a search.
  logic [BW-1:0] cand;
  logic          cand_wrap;
  logic          table_full;
  logic          rel_in_range;

  assign cand         = last_given_q + BW'(1);
  assign cand_wrap    = (cand >= MaxIdsB);
  assign table_full   = (32'(live_count_q) >= 32'(TABLE_DEPTH)) ||
                        (32'(live_count_q) >= 32'(MAX_IDS - 1));
  assign rel_in_range = (32'(released_pid_i) < 32'(MAX_IDS));

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      last_given_q   <= MaxIdsB;
      safe_bound_q   <= MaxIdsB;
      live_count_q   <= '0;
      launch_ctrl_q  <= '0;
      launch_key_q   <= '0;
      launch_bound_q <= '0;
      res_pid_q      <= '0;
      res_status_q   <= cpida_pkg::ST_OK;
      out_valid_q    <= 1'b0;
      new_pid_q      <= '0;
      status_q       <= cpida_pkg::ST_OK;
    end else begin
      // In the done state the output register is refilled below instead.
      if (state_q != S_DONE && out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            res_pid_q      <= '0;
            launch_bound_q <= MaxIdsB;
            if (opcode_i == cpida_pkg::OP_RELEASE) begin
              if (rel_in_range) begin
                launch_ctrl_q <= '{vld: 1'b1, op: cpida_pkg::TOK_RELEASE, hit: 1'b0};
                launch_key_q  <= IdW'(released_pid_i);
                state_q       <= S_PASS;
              end else begin
                // An identifier outside the space can never be live.
                res_status_q <= cpida_pkg::ST_NOT_FOUND;
                state_q      <= S_DONE;
              end
            end else if (table_full) begin
              res_status_q <= cpida_pkg::ST_FULL;
              state_q      <= S_DONE;
            end else if (cand_wrap) begin
              launch_ctrl_q <= '{vld: 1'b1, op: cpida_pkg::TOK_SEARCH, hit: 1'b0};
              launch_key_q  <= IdW'(1);
              state_q       <= S_PASS;
            end else if (cand >= safe_bound_q) begin
              launch_ctrl_q <= '{vld: 1'b1, op: cpida_pkg::TOK_SEARCH, hit: 1'b0};
              launch_key_q  <= cand[IdW-1:0];
              state_q       <= S_PASS;
            end else begin
              // Below the safe bound the candidate is known to be free.
              launch_ctrl_q <= '{vld: 1'b1, op: cpida_pkg::TOK_INSERT, hit: 1'b0};
              launch_key_q  <= cand[IdW-1:0];
              state_q       <= S_PASS;
            end
          end
        end

        S_PASS: begin
          if (tail_ctrl.vld) begin
            case (tail_ctrl.op)
              cpida_pkg::TOK_SEARCH: begin
                launch_key_q   <= tail_key;
                launch_bound_q <= MaxIdsB;
                if (tail_ctrl.hit) begin
                  // The candidate moved during this pass, so an earlier slot may now
                  // match it: walk the table again.
                  launch_ctrl_q <= '{vld: 1'b1, op: cpida_pkg::TOK_SEARCH, hit: 1'b0};
                end else begin
                  // A clean pass: the candidate is free and the bound is exact.
                  safe_bound_q  <= tail_bound;
                  launch_ctrl_q <= '{vld: 1'b1, op: cpida_pkg::TOK_INSERT, hit: 1'b0};
                end
              end
              cpida_pkg::TOK_INSERT: begin
                last_given_q <= {1'b0, tail_key};
                live_count_q <= live_count_q + CntW'(1);
                res_pid_q    <= cpida_pkg::PID_W'(tail_key);
                res_status_q <= cpida_pkg::ST_OK;
                state_q      <= S_DONE;
              end
              cpida_pkg::TOK_RELEASE: begin
                if (tail_ctrl.hit) begin
                  live_count_q <= live_count_q - CntW'(1);
                  res_status_q <= cpida_pkg::ST_OK;
                end else begin
                  res_status_q <= cpida_pkg::ST_NOT_FOUND;
                end
                state_q <= S_DONE;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end else begin
            // A launched token stays in the first cell for one cycle only; the tail
            // is always empty in the cycle right after a launch.
            launch_ctrl_q.vld <= 1'b0;
          end
        end

        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            new_pid_q   <= res_pid_q;
            status_q    <= res_status_q;
            state_q     <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign new_pid_o   = new_pid_q;
  assign status_o    = status_q;

`ifndef SYNTHESIS
  // The live count never exceeds the number of table slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(live_count_q) <= 32'(TABLE_DEPTH))
    else $error("live count exceeds the table depth");

  // A failed request always reports identifier zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_q != cpida_pkg::ST_OK) |-> new_pid_o == '0)
    else $error("nonzero identifier on a failed request");

  // Tokens only come back from the row while a pass is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_ctrl.vld |-> state_q == S_PASS)
    else $error("token returned outside a pass");

  // The cached bound stays inside the identifier space.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    safe_bound_q <= MaxIdsB && safe_bound_q != '0)
    else $error("safe bound out of range");
`endif

endmodule

FILE: tb/sv/cyclic_process_id_allocator_core_tb.sv
// Self-checking testbench for the cyclic process identifier allocator core.
`timescale 1ns / 1ps

module cyclic_process_id_allocator_core_tb;
  import cpida_pkg::*;

  // The block runs at its default sizes; the predictor mirrors them.
  localparam int MAX_IDS      = MAX_IDS_DEF;
  localparam int TABLE_DEPTH  = TABLE_DEPTH_DEF;
  // A search may need one table pass per live entry. The limit covers that worst case
  // plus the longest idle bursts for every request of the run, several times over.
  localparam int LIMIT_CYCLES = 4 * 750 * ((TABLE_DEPTH + 2) * (TABLE_DEPTH + 1) + 40);

  // One expected result beat.
  typedef struct {
    logic [PID_W-1:0] pid;
    status_e          status;
  } alloc_reply_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                opcode_i;
  logic [PID_W-1:0]    released_pid_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [PID_W-1:0]    new_pid_o;
  logic [STATUS_W-1:0] status_o;

  // Replies that the block still owes, oldest first.
  alloc_reply_t expected_replies[$];
  int           mismatch_count = 0;
  int           cycle_count = 0;

  // Knobs shared by the tests and the idling processes.
  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;
  int rx_hold_cycles = 0;

  // The predictor's own copy of the allocator state. Slot contents are only
  // looked at where the matching busy bit is set.
  logic [PID_W-1:0] slot_pid [TABLE_DEPTH];
  bit               slot_busy [TABLE_DEPTH];
  int unsigned      prev_given = MAX_IDS;
  int unsigned      safe_limit = MAX_IDS;
  int unsigned      live_cnt = 0;

  cyclic_process_id_allocator_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .released_pid_i (released_pid_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .new_pid_o      (new_pid_o),
    .status_o       (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Applies one accepted request to the predicted state and returns the beat
  // the block must answer with.
  function automatic alloc_reply_t predict_request(logic op, logic [PID_W-1:0] rel_pid);
    alloc_reply_t res;
    int unsigned  cand;
    int unsigned  new_limit;
    int unsigned  restarts;
    int           idx;
    bit           found;
    bit           need_scan;
    bit           capped;
    bit           rescan;

    res.pid    = '0;
    res.status = ST_OK;

    if (op == OP_RELEASE) begin
      // Only a busy slot holding exactly this identifier counts; zero never does.
      found = 1'b0;
      for (int s = 0; s < TABLE_DEPTH && !found; s++) begin
        if (slot_busy[s] && slot_pid[s] == rel_pid) begin
          slot_busy[s] = 1'b0;
          live_cnt--;
          found = 1'b1;
        end
      end
      res.status = found ? ST_OK : ST_NOT_FOUND;
      return res;
    end

    // A full table, or an exhausted identifier space, leaves everything as it is.
    if (live_cnt >= TABLE_DEPTH || live_cnt >= MAX_IDS - 1) begin
      res.status = ST_FULL;
      return res;
    end

    cand      = prev_given + 1;
    need_scan = 1'b0;
    if (cand >= MAX_IDS) begin
      cand      = 1;
      need_scan = 1'b1;
    end else if (cand >= safe_limit) begin
      need_scan = 1'b1;
    end

    if (need_scan) begin
      // Walk the slots; each hit bumps the candidate, and when the candidate
      // reaches the smallest live identifier seen above it the walk starts over.
      new_limit = MAX_IDS;
      restarts  = 0;
      capped    = 1'b0;
      idx       = 0;
      while (idx < TABLE_DEPTH && !capped) begin
        rescan = 1'b0;
        if (slot_busy[idx]) begin
          if (slot_pid[idx] == cand) begin
            cand++;
            if (cand >= new_limit) begin
              if (cand >= MAX_IDS) cand = 1;
              new_limit = MAX_IDS;
              restarts++;
              if (restarts > 2 * MAX_IDS + 2) capped = 1'b1;
              rescan = 1'b1;
            end
          end else if (slot_pid[idx] > cand && new_limit > slot_pid[idx]) begin
            new_limit = slot_pid[idx];
          end
        end
        idx = rescan ? 0 : idx + 1;
      end
      if (capped) begin
        res.status = ST_FULL;
        return res;
      end
      safe_limit = new_limit;
    end

    // The new identifier goes into the lowest free slot.
    prev_given = cand;
    found      = 1'b0;
    for (int s = 0; s < TABLE_DEPTH && !found; s++) begin
      if (!slot_busy[s]) begin
        slot_busy[s] = 1'b1;
        slot_pid[s]  = cand[PID_W-1:0];
        live_cnt++;
        found = 1'b1;
      end
    end
    res.pid = cand[PID_W-1:0];
    return res;
  endfunction

  // Picks an identifier that the predictor holds as live, or any value when
  // nothing is live.
  function automatic logic [PID_W-1:0] pick_live_pid();
    int busy_slots[$];
    logic [PID_W-1:0] any_pid;
    any_pid = PID_W'($urandom_range(0, MAX_IDS - 1));
    foreach (slot_busy[s]) if (slot_busy[s]) busy_slots.push_back(s);
    if (busy_slots.size() == 0) return any_pid;
    return slot_pid[busy_slots[$urandom_range(0, busy_slots.size() - 1)]];
  endfunction

  // Mostly a live identifier, sometimes any 7-bit value, which is usually absent.
  function automatic logic [PID_W-1:0] pick_release_pid();
    logic [PID_W-1:0] any_pid;
    any_pid = PID_W'($urandom_range(0, MAX_IDS - 1));
    return ($urandom_range(0, 4) == 0) ? any_pid : pick_live_pid();
  endfunction

  // Offers one request beat and returns at the edge where it is taken. Must be
  // called at a rising edge. An optional idle burst comes first. Valid is only
  // lowered inside that burst, so back-to-back beats keep it high.
  task automatic send_request(input logic op, input logic [PID_W-1:0] pid);
    int gap;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    released_pid_i <= pid;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    expected_replies.push_back(predict_request(op, pid));
  endtask

  // Sends a random allocate; the identifier field is ignored but still toggles.
  task automatic send_alloc();
    logic [PID_W-1:0] junk;
    junk = PID_W'($urandom_range(0, MAX_IDS - 1));
    send_request(OP_ALLOC, junk);
  endtask

  function automatic void note_mismatch(string what, int want, int got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch at cycle %0d: %s expected %0d, got %0d",
               cycle_count, what, want, got);
  endfunction

  // Result side: outputs are sampled just before the edge at which the beat moves,
  // then compared with the oldest prediction field by field.
  always @(posedge clk_i) begin : reply_checker
    alloc_reply_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_replies.size() == 0) begin
        note_mismatch("unrequested beat, new_pid", 0, int'(new_pid_o));
      end else begin
        want = expected_replies.pop_front();
        if (new_pid_o !== want.pid)
          note_mismatch("new_pid", int'(want.pid), int'(new_pid_o));
        if (status_o !== want.status)
          note_mismatch("status", int'(want.status), int'(status_o));
      end
    end
  end

  // Result side stall: random bursts, and on request one long hold counted here.
  initial begin : stall_driver
    int burst;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_cycles != 0) begin
        out_stall_i <= 1'b1;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
        out_stall_i <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 17);
        out_stall_i <= 1'b1;
        repeat (burst) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Stops a hung run.
  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Edge values of the release field, absent identifiers including zero, the
  // first allocation wrapping from the reset value to 1, the fast path, and a
  // release of an identifier that was already released.
  task automatic test_directed();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_request(OP_RELEASE, 7'd0);
    send_request(OP_RELEASE, 7'd127);
    send_request(OP_RELEASE, 7'b1010101);
    send_request(OP_ALLOC, 7'b0101010);
    send_request(OP_ALLOC, 7'd127);
    send_request(OP_ALLOC, 7'd0);
    send_request(OP_RELEASE, 7'd2);
    send_request(OP_RELEASE, 7'd2);
    send_request(OP_ALLOC, 7'd0);
    send_request(OP_RELEASE, 7'd1);
    send_request(OP_RELEASE, 7'd0);
    send_request(OP_RELEASE, 7'b0101010);
    send_request(OP_RELEASE, 7'd3);
    send_request(OP_RELEASE, 7'd4);
    send_request(OP_ALLOC, 7'b1111111);
    send_request(OP_RELEASE, 7'd5);
    send_request(OP_ALLOC, 7'd1);
    send_request(OP_RELEASE, 7'd127);
  endtask

  // Fills every slot, asks past the limit, frees a few, refills, then empties it.
  task automatic test_fill_to_full();
    int k;
    for (k = 0; k < TABLE_DEPTH + 4; k++) send_alloc();
    for (k = 0; k < 8; k++) send_request(OP_RELEASE, pick_live_pid());
    for (k = 0; k < 10; k++) send_alloc();
    while (live_cnt != 0) send_request(OP_RELEASE, pick_live_pid());
  endtask

  // The result side holds off for a long time while requests keep coming, so the
  // core backs up and stalls its input; the queued requests drain afterwards.
  task automatic test_output_hold();
    int k;
    tx_idle_on     = 1'b0;
    rx_idle_on     = 1'b0;
    rx_hold_cycles = 6 * TABLE_DEPTH;
    for (k = 0; k < 16; k++) begin
      if (k % 3 == 2) send_request(OP_RELEASE, pick_live_pid());
      else send_alloc();
    end
  endtask

  // The request side goes quiet until every reply is back, then resumes.
  task automatic test_drain_then_resume();
    int k;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_replies.size() != 0) @(posedge clk_i);
    for (k = 0; k < 6; k++) begin
      if (k % 2 == 0) send_alloc();
      else send_request(OP_RELEASE, pick_release_pid());
    end
  endtask

  // Random traffic in chunks that lean toward filling, draining or neither, so the
  // count swings between empty and full and the last identifier wraps often.
  // Idling changes per chunk; the final stretch runs without any.
  task automatic test_random_traffic(input int n_items);
    int k;
    int alloc_pct;
    alloc_pct = 50;
    for (k = 0; k < n_items; k++) begin
      if (k % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       alloc_pct = 85;
          1:       alloc_pct = 50;
          default: alloc_pct = 20;
        endcase
        tx_idle_on = (k < n_items - 100) && ($urandom_range(0, 2) != 0);
        rx_idle_on = (k < n_items - 100) && ($urandom_range(0, 2) != 0);
      end
      if ($urandom_range(0, 99) < alloc_pct) send_alloc();
      else send_request(OP_RELEASE, pick_release_pid());
    end
  endtask

  initial begin : run_tests
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    opcode_i       <= OP_ALLOC;
    released_pid_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_fill_to_full();
    test_output_hold();
    test_drain_then_resume();
    test_random_traffic(560);

    // Let every outstanding reply come back, then keep the clock running idle in case
    // the block emits something it should not.
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (2 * TABLE_DEPTH + 8) @(posedge clk_i);

    if (mismatch_count == 0 && expected_replies.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
